// ----- src/dns_a_query_synthesizer_core_macros.svh -----
// Assertion macros used by the checker file of the DNS A-query synthesizer.
// Depends on signals named clk and arst_n in the module that uses them.
`ifndef DNS_A_QUERY_SYNTHESIZER_CORE_MACROS_SVH
`define DNS_A_QUERY_SYNTHESIZER_CORE_MACROS_SVH

// Implication checked on every rising edge once reset is released.
`define DNSQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, also evaluated while reset is held.
`define DNSQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dnsq_pkg.sv -----
// Shared types, constants and record helpers of the DNS A-query synthesizer.
// No dependencies; the parser, queue, emitter, top level and checker import this package.
package dnsq_pkg;

	localparam int MAX_PACKET = 2048;
	localparam int POS_W      = $clog2(MAX_PACKET + 1);
	localparam int HDR_LEN    = 12;
	localparam int REC_LEN    = 16;
	localparam int IDX_W      = $clog2(REC_LEN);
	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [31:0] POOL_FIRST_RST = 32'hC612_0001;
	localparam logic [31:0] POOL_LAST_RST  = 32'hC613_FFFE;
	localparam logic [31:0] TTL_RST        = 32'd60;
	localparam logic [15:0] QTYPE_A        = 16'h0001;

	typedef enum logic [1:0] {
		CFG_POOL_FIRST = 2'd0,
		CFG_POOL_LAST  = 2'd1,
		CFG_TTL        = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		VERDICT_DROP  = 2'd0,
		VERDICT_SYNTH = 2'd1,
		VERDICT_PASS  = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LABEL_LEN,
		PH_LABEL_BODY,
		PH_TAIL
	} parse_phase_t;

	// One classified packet, handed from the parser to the emitter.
	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] address;
		logic [15:0] qtype;
		logic [31:0] queries;
		logic [31:0] answers;
	} desc_t;

	// Byte of the answer record: name pointer, type A, class IN, TTL, length, address.
	function automatic logic [7:0] rec_byte(input logic [IDX_W-1:0] idx,
			input logic [31:0] ttl, input logic [31:0] addr);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'hC0;
			4'd1:    b = 8'h0C;
			4'd2:    b = 8'h00;
			4'd3:    b = 8'h01;
			4'd4:    b = 8'h00;
			4'd5:    b = 8'h01;
			4'd6:    b = ttl[31:24];
			4'd7:    b = ttl[23:16];
			4'd8:    b = ttl[15:8];
			4'd9:    b = ttl[7:0];
			4'd10:   b = 8'h00;
			4'd11:   b = 8'h04;
			4'd12:   b = addr[31:24];
			4'd13:   b = addr[23:16];
			4'd14:   b = addr[15:8];
			default: b = addr[7:0];
		endcase
		return b;
	endfunction

endpackage

// ----- src/dnsq_if.sv -----
// Handshake channels of the DNS A-query synthesizer: packet bytes in, results out.
// Depends on nothing; each carries valid, ready and its payload fields.
interface dnsq_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pkt_byte;
	logic       pkt_last;

	modport source (output valid, output pkt_byte, output pkt_last, input ready);
	modport sink (input valid, input pkt_byte, input pkt_last, output ready);
endinterface

interface dnsq_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  answer_byte;
	logic        answer_valid;
	logic [1:0]  verdict;
	logic [31:0] synthetic_address;
	logic [15:0] query_type;
	logic [31:0] queries_seen;
	logic [31:0] answers_made;
	logic        result_last;

	modport source (output valid, output answer_byte, output answer_valid, output verdict,
		output synthetic_address, output query_type, output queries_seen,
		output answers_made, output result_last, input ready);
	modport sink (input valid, input answer_byte, input answer_valid, input verdict,
		input synthetic_address, input query_type, input queries_seen,
		input answers_made, input result_last, output ready);
endinterface

// ----- src/dnsq_parser.sv -----
// Front part: parses query bytes, allocates pool addresses and classifies packets.
// Depends on dnsq_pkg; pushes one descriptor per packet into the queue.
module dnsq_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic                in_ready,
	input  logic                queue_full,
	output logic                push,
	output dnsq_pkg::desc_t     push_desc,
	input  logic [31:0]         pool_first,
	input  logic [31:0]         pool_last
);
	import dnsq_pkg::*;

	logic [POS_W-1:0] pos_q, pos_n;
	parse_phase_t     phase_q, phase_n;
	logic [7:0]       skip_q, skip_n;
	logic [15:0]      qtype_q, qtype_n;
	logic [2:0]       bat_q, bat_n;
	logic [31:0]      next_addr_q, addr_inc;
	logic [31:0]      queries_q, answers_q;
	logic             accept, pos_ok, long_enough, qtype_ok, is_a;
	logic [15:0]      qtype_final;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign pos_ok   = pos_q < POS_W'(MAX_PACKET);

	// Parse state after this byte.
	always_comb begin
		phase_n = phase_q;
		skip_n  = skip_q;
		qtype_n = qtype_q;
		bat_n   = bat_q;
		pos_n   = pos_q;
		if (pos_ok) begin
			pos_n = pos_q + 1'b1;
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q >= POS_W'(HDR_LEN - 1))
						phase_n = PH_LABEL_LEN;
				end
				PH_LABEL_LEN: begin
					if (in_byte == 8'h00) begin
						phase_n = PH_TAIL;
					end else begin
						skip_n  = in_byte;
						phase_n = PH_LABEL_BODY;
					end
				end
				PH_LABEL_BODY: begin
					if (skip_q != 8'd0)
						skip_n = skip_q - 1'b1;
					if (skip_n == 8'd0)
						phase_n = PH_LABEL_LEN;
				end
				PH_TAIL: begin
					if (bat_q == 3'd0)
						qtype_n = {in_byte, 8'h00};
					else if (bat_q == 3'd1)
						qtype_n = {qtype_q[15:8], in_byte};
					if (bat_q < 3'd4)
						bat_n = bat_q + 1'b1;
				end
				default: phase_n = PH_HEADER;
			endcase
		end
	end

	assign long_enough = pos_n >= POS_W'(HDR_LEN);
	assign qtype_ok    = (phase_n == PH_TAIL) && (bat_n >= 3'd4);
	assign qtype_final = qtype_ok ? qtype_n : 16'h0000;
	assign is_a        = long_enough && (qtype_final == QTYPE_A);
	assign addr_inc    = next_addr_q + 32'd1;

	assign push = accept && in_last;

	always_comb begin
		push_desc.verdict = VERDICT_DROP;
		push_desc.address = 32'd0;
		push_desc.qtype   = 16'h0000;
		push_desc.queries = queries_q;
		push_desc.answers = answers_q;
		if (long_enough) begin
			push_desc.queries = queries_q + 32'd1;
			push_desc.qtype   = qtype_final;
			push_desc.verdict = VERDICT_PASS;
			if (is_a) begin
				push_desc.verdict = VERDICT_SYNTH;
				push_desc.address = next_addr_q;
				push_desc.answers = answers_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			phase_q     <= PH_HEADER;
			skip_q      <= '0;
			qtype_q     <= '0;
			bat_q       <= '0;
			next_addr_q <= POOL_FIRST_RST;
			queries_q   <= '0;
			answers_q   <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q     <= '0;
				phase_q   <= PH_HEADER;
				skip_q    <= '0;
				qtype_q   <= '0;
				bat_q     <= '0;
				queries_q <= push_desc.queries;
				answers_q <= push_desc.answers;
				if (is_a)
					next_addr_q <= (addr_inc > pool_last) ? pool_first : addr_inc;
			end else begin
				pos_q   <= pos_n;
				phase_q <= phase_n;
				skip_q  <= skip_n;
				qtype_q <= qtype_n;
				bat_q   <= bat_n;
			end
		end
	end

endmodule

// ----- src/dnsq_desc_fifo.sv -----
// Short descriptor queue between the parser and the emitter.
// Depends on dnsq_pkg for the descriptor type and depth.
module dnsq_desc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dnsq_pkg::desc_t push_desc,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output dnsq_pkg::desc_t head
);
	import dnsq_pkg::*;

	desc_t              entry_q [FIFO_DEPTH];
	logic [FPTR_W-1:0]  wr_q, rd_q;
	logic [FCNT_W-1:0]  count_q;

	assign full      = count_q == FCNT_W'(FIFO_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- src/dnsq_emitter.sv -----
// Back part: expands each descriptor into result transactions through an output register.
// Depends on dnsq_pkg for the descriptor type and the record byte table.
module dnsq_emitter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            desc_avail,
	input  dnsq_pkg::desc_t head,
	output logic            pop,
	input  logic [31:0]     ttl,
	dnsq_out_if.source      out_ch
);
	import dnsq_pkg::*;

	desc_t            desc_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic             out_free, load_out, is_end, fin, synth;

	assign synth    = desc_q.verdict == VERDICT_SYNTH;
	assign out_free = !out_valid_q || out_ch.ready;
	assign load_out = busy_q && out_free;
	assign is_end   = !synth || (idx_q == IDX_W'(REC_LEN - 1));
	assign fin      = load_out && is_end;
	assign pop      = desc_avail && (!busy_q || fin);

	assign out_ch.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				busy_q <= 1'b1;
			else if (fin)
				busy_q <= 1'b0;
			if (pop)
				idx_q <= '0;
			else if (load_out)
				idx_q <= idx_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			desc_q <= head;
		if (load_out) begin
			out_ch.answer_byte       <= synth ? rec_byte(idx_q, ttl, desc_q.address) : 8'h00;
			out_ch.answer_valid      <= synth;
			out_ch.verdict           <= desc_q.verdict;
			out_ch.synthetic_address <= desc_q.address;
			out_ch.query_type        <= desc_q.qtype;
			out_ch.queries_seen      <= desc_q.queries;
			out_ch.answers_made      <= desc_q.answers;
			out_ch.result_last       <= is_end;
		end
	end

endmodule

// ----- src/dns_a_query_synthesizer_core.sv -----
// Top level of the DNS A-query synthesizer: configuration registers and the
// parser, descriptor queue and emitter. Depends on dnsq_pkg, dnsq_if and the three parts.
//
// Usage: query packets enter on in_ch one byte per transaction, pkt_last marking
// the final byte. Bytes past 2048 in a packet are not parsed. Each packet gives
// result transactions on out_ch: sixteen answer record bytes for a type A query
// (name pointer, type, class, TTL, length, pool address), otherwise a single
// transaction with answer_valid low and the verdict (drop or passthrough).
// Throughput: one input byte per cycle sustained as long as packets are at least as
// long as the results they cause; results leave at one per cycle while out_ch is ready.
// With the emitter idle, a packet's descriptor goes from the queue entry through the
// emitter's descriptor register to the output register before its first result is valid.
// A four-entry descriptor queue separates the parser from the emitter, so the parser
// keeps taking bytes while answers stream out; in_ch ready drops only when that queue
// is full, which happens when out_ch stalls or when four short packets wait behind
// an answer that is still streaming. When the receiver holds ready low, the output
// register keeps its transaction unchanged and the emitter waits.
// Reset clears all parse state and counters, returns the pool pointer to its
// reset first address and loads the reset register values. Only while the block is
// idle does the user write configuration via cfg_we/cfg_index/cfg_wdata (not enforced).
module dns_a_query_synthesizer_core (
	input  logic        clk,
	input  logic        arst_n,
	dnsq_in_if.sink     in_ch,
	dnsq_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import dnsq_pkg::*;

	// Configuration registers. Writing the pool bounds does not move the pool
	// pointer; only reset and a wrap load it.
	logic [31:0] pool_first_q, pool_last_q, ttl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_first_q <= POOL_FIRST_RST;
			pool_last_q  <= POOL_LAST_RST;
			ttl_q        <= TTL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POOL_FIRST: pool_first_q <= cfg_wdata;
				CFG_POOL_LAST:  pool_last_q  <= cfg_wdata;
				CFG_TTL:        ttl_q        <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// Queue signals between the front and back parts.
	logic  queue_full, push, pop, desc_avail;
	desc_t push_desc, head;

	dnsq_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_byte    (in_ch.pkt_byte),
		.in_last    (in_ch.pkt_last),
		.in_ready   (in_ch.ready),
		.queue_full (queue_full),
		.push       (push),
		.push_desc  (push_desc),
		.pool_first (pool_first_q),
		.pool_last  (pool_last_q)
	);

	dnsq_desc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (desc_avail),
		.head      (head)
	);

	// TTL is read live; change it only while no answer is in flight (not enforced).
	dnsq_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_avail (desc_avail),
		.head       (head),
		.pop        (pop),
		.ttl        (ttl_q),
		.out_ch     (out_ch)
	);

endmodule

// ----- src/dnsq_checker.sv -----
// Port-level checker for the DNS A-query synthesizer and its bind statement.
// Depends on dns_a_query_synthesizer_core_macros.svh, dnsq_pkg and the top level's ports.
`include "dns_a_query_synthesizer_core_macros.svh"

module dnsq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  answer_byte,
	input logic        answer_valid,
	input logic [1:0]  verdict,
	input logic        result_last
);
	import dnsq_pkg::*;

	// A held result keeps its byte and its last flag until it is taken.
	`DNSQ_ASSERT(a_hold, out_valid && !out_ready |=> $stable(answer_byte) && $stable(result_last), "result changed while stalled")

	// Record bytes belong only to synthesized answers.
	`DNSQ_ASSERT(a_rec_synth, out_valid && answer_valid |-> verdict == VERDICT_SYNTH, "record byte without synthesize verdict")

	// Drop and passthrough verdicts are single, final, empty transactions.
	`DNSQ_ASSERT(a_single, out_valid && verdict != VERDICT_SYNTH |-> result_last && !answer_valid, "non-answer verdict not a single final result")

	// Once a record byte is taken, the next record byte follows without a gap.
	`DNSQ_ASSERT(a_no_gap, out_valid && out_ready && answer_valid && !result_last |=> out_valid && answer_valid, "gap inside an answer record")

	// No result can appear during reset.
	`DNSQ_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind dns_a_query_synthesizer_core dnsq_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.answer_byte  (out_ch.answer_byte),
	.answer_valid (out_ch.answer_valid),
	.verdict      (out_ch.verdict),
	.result_last  (out_ch.result_last)
);
